// ===== rtl/cmplog_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmplog_pkg
// Shared types, constants and helper functions of the comparison operand
// logger: stream field layout, header entry format and operand sizing.
// ----------------------------------------------------------------------------
package cmplog_pkg;

    // Default table geometry (both must be powers of two)
    localparam int KEYS_DEF  = 1024;
    localparam int SLOTS_DEF = 32;

    // Fixed field widths
    localparam int ADDR_W    = 64;
    localparam int CODE_W    = 2;
    localparam int VAL_W     = 64;
    localparam int KEY_W     = 10;
    localparam int SLOT_W    = 5;
    localparam int HITS_W    = 32;
    localparam int SHAPE_W   = 3;

    // Key hash shift amounts
    localparam int HASH_SHR  = 4;
    localparam int HASH_SHL  = 8;

    // Stream payload widths (packed fields rounded up to whole bytes)
    localparam int IN_BITS   = ADDR_W + CODE_W + 2 * VAL_W + KEY_W + SLOT_W;
    localparam int IN_DATA_W = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS  = KEY_W + HITS_W + SLOT_W + SHAPE_W + 1 + 2 * VAL_W;
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

    // APB register map
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam logic REG_LOG_ENABLE = 1'b0;   // word index of log_enable

    // Item action codes
    localparam logic ACT_RECORD = 1'b0;
    localparam logic ACT_READ   = 1'b1;

    // Entry kind codes
    localparam logic KIND_NONE  = 1'b0;
    localparam logic KIND_INSN  = 1'b1;

    // Operand size codes
    localparam logic [CODE_W-1:0] SIZE_1B = 2'd0;
    localparam logic [CODE_W-1:0] SIZE_2B = 2'd1;
    localparam logic [CODE_W-1:0] SIZE_4B = 2'd2;
    localparam logic [CODE_W-1:0] SIZE_8B = 2'd3;

    // Header entry held per key
    typedef struct packed {
        logic               kind;
        logic [SHAPE_W-1:0] shape;
        logic [HITS_W-1:0]  hits;
    } hdr_t;

    localparam int HDR_W = $bits(hdr_t);

    // Engine control state
    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOK
    } eng_state_t;

    // Engine status seen by the top level
    typedef struct packed {
        logic clearing;
        logic busy;
    } eng_status_t;

    // Size in bytes minus one
    function automatic logic [SHAPE_W-1:0] shape_of(input logic [CODE_W-1:0] code);
        logic [SHAPE_W-1:0] s;
        begin
            case (code)
                SIZE_1B: s = 3'd0;
                SIZE_2B: s = 3'd1;
                SIZE_4B: s = 3'd3;
                SIZE_8B: s = 3'd7;
                default: s = 3'd0;
            endcase
            return s;
        end
    endfunction

    // Cut an operand to its size
    function automatic logic [VAL_W-1:0] size_cut(input logic [CODE_W-1:0] code,
                                                 input logic [VAL_W-1:0]  v);
        logic [VAL_W-1:0] r;
        begin
            case (code)
                SIZE_1B: r = {56'd0, v[7:0]};
                SIZE_2B: r = {48'd0, v[15:0]};
                SIZE_4B: r = {32'd0, v[31:0]};
                SIZE_8B: r = v;
                default: r = v;
            endcase
            return r;
        end
    endfunction

endpackage

// ===== rtl/comparison_operand_logger_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// comparison_operand_logger_core
// Records comparison operands per hashed call-site key and reads back
// key headers and logged operand pairs.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake                  Carries
//  s_*       in         s_tvalid / s_tready        record or read item
//  m_*       out        m_tvalid / m_tready        one result per item
//  APB       in         psel & penable & pwrite    log_enable register
//
//  An item is handled as a header memory read, then the output register
//  load, with the header write-back for a record while logging is enabled.
//  The next item is taken the cycle after write-back, so the header memory
//  needs no forwarding. After reset a clearing pass zeroes the header
//  memory, during which s_tready stays low. A full output register stalls
//  the write-back; an item may still be taken while a result waits.
// ----------------------------------------------------------------------------
module comparison_operand_logger_core
    import cmplog_pkg::*;
#(
    parameter int KEYS  = KEYS_DEF,
    parameter int SLOTS = SLOTS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    // input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // [63:0] call_site, [65:64] size_code, [129:66] operand_a,
    // [193:130] operand_b, [203:194] read_key, [208:204] read_slot
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // [0] action
    input  logic                  s_tuser,
    // output stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [9:0] key, [41:10] hit_count, [46:42] slot, [49:47] entry_shape,
    // [50] entry_kind, [114:51] value_a, [178:115] value_b
    output logic [OUT_DATA_W-1:0] m_tdata,
    // [0] done_res
    output logic                  m_tuser,
    // configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int KW = $clog2(KEYS);
    localparam int LW = $clog2(KEYS) + $clog2(SLOTS);

    logic              log_enable;
    logic              hdr_we;
    logic [KW-1:0]     hdr_waddr;
    hdr_t              hdr_wdata;
    logic              hdr_re;
    logic [KW-1:0]     hdr_raddr;
    hdr_t              hdr_rdata;
    logic              log_we;
    logic [LW-1:0]     log_waddr;
    logic [2*VAL_W-1:0] log_wdata;
    logic              log_re;
    logic [LW-1:0]     log_raddr;
    logic [2*VAL_W-1:0] log_rdata;
    eng_status_t       status;

    // Register file
    cmplog_cfg u_cfg (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .log_enable (log_enable)
    );

    // Per-key header memory
    cmplog_ram #(
        .DEPTH (KEYS),
        .WIDTH (HDR_W)
    ) u_hdr_ram (
        .clk   (clk),
        .we    (hdr_we),
        .waddr (hdr_waddr),
        .wdata (hdr_wdata),
        .re    (hdr_re),
        .raddr (hdr_raddr),
        .rdata (hdr_rdata)
    );

    // Operand pair log, one row per key and slot
    cmplog_ram #(
        .DEPTH (KEYS * SLOTS),
        .WIDTH (2 * VAL_W)
    ) u_log_ram (
        .clk   (clk),
        .we    (log_we),
        .waddr (log_waddr),
        .wdata (log_wdata),
        .re    (log_re),
        .raddr (log_raddr),
        .rdata (log_rdata)
    );

    // Control and datapath
    cmplog_engine #(
        .KEYS  (KEYS),
        .SLOTS (SLOTS)
    ) u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .log_enable (log_enable),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .hdr_we     (hdr_we),
        .hdr_waddr  (hdr_waddr),
        .hdr_wdata  (hdr_wdata),
        .hdr_re     (hdr_re),
        .hdr_raddr  (hdr_raddr),
        .hdr_rdata  (hdr_rdata),
        .log_we     (log_we),
        .log_waddr  (log_waddr),
        .log_wdata  (log_wdata),
        .log_re     (log_re),
        .log_raddr  (log_raddr),
        .log_rdata  (log_rdata),
        .status     (status)
    );

    // No item is taken during the clearing pass
    a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> !status.clearing)
        else $error("item accepted during header clearing pass");

    // One item in flight: a transfer closes the input for the next cycle
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second item accepted while one is in flight");

    // Operands are logged only while logging is enabled
    a_log_when_enabled: assert property (@(posedge clk) disable iff (!rst_n)
        log_we |-> (log_enable && status.busy))
        else $error("operand log written while disabled or idle");

    // A header write-back always produces a result
    a_writeback_result: assert property (@(posedge clk) disable iff (!rst_n)
        (hdr_we && !status.clearing) |=> m_tvalid)
        else $error("header write-back without a result");

endmodule

// ===== rtl/cmplog_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmplog_ram
// Simple dual-port synchronous RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module cmplog_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, data held until the next read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/cmplog_cfg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmplog_cfg
// APB register file: holds the log enable register.
// ----------------------------------------------------------------------------
module cmplog_cfg
    import cmplog_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    output logic                  log_enable
);

    logic log_enable_reg;
    logic log_enable_next;
    logic word_hit;
    logic wr_fire;

    // Decode word address
    assign word_hit = (paddr[CFG_ADDR_W-1] == REG_LOG_ENABLE);
    assign pready   = 1'b1;
    assign wr_fire  = psel && penable && pwrite && pready;

    // Update register on a completed write transfer
    always_comb
    begin
        log_enable_next = log_enable_reg;
        if (wr_fire && word_hit)
        begin
            log_enable_next = pwdata[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            log_enable_reg <= 1'b0;
        end
        else
        begin
            log_enable_reg <= log_enable_next;
        end
    end

    // Read back
    assign prdata     = word_hit ? {{(CFG_DATA_W-1){1'b0}}, log_enable_reg}
                                 : '0;
    assign log_enable = log_enable_reg;

endmodule

// ===== rtl/cmplog_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmplog_engine
// Control and datapath: header clearing pass, key hashing, header
// read-modify-write, operand log access and the output register.
// ----------------------------------------------------------------------------
module cmplog_engine
    import cmplog_pkg::*;
#(
    parameter int KEYS  = KEYS_DEF,
    parameter int SLOTS = SLOTS_DEF
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      log_enable,
    // input stream
    input  logic                                      s_tvalid,
    output logic                                      s_tready,
    input  logic [IN_DATA_W-1:0]                      s_tdata,
    input  logic                                      s_tuser,
    // output stream
    output logic                                      m_tvalid,
    input  logic                                      m_tready,
    output logic [OUT_DATA_W-1:0]                     m_tdata,
    output logic                                      m_tuser,
    // header memory
    output logic                                      hdr_we,
    output logic [$clog2(KEYS)-1:0]                   hdr_waddr,
    output hdr_t                                      hdr_wdata,
    output logic                                      hdr_re,
    output logic [$clog2(KEYS)-1:0]                   hdr_raddr,
    input  hdr_t                                      hdr_rdata,
    // operand log memory
    output logic                                      log_we,
    output logic [$clog2(KEYS)+$clog2(SLOTS)-1:0]     log_waddr,
    output logic [2*VAL_W-1:0]                        log_wdata,
    output logic                                      log_re,
    output logic [$clog2(KEYS)+$clog2(SLOTS)-1:0]     log_raddr,
    input  logic [2*VAL_W-1:0]                        log_rdata,
    // status
    output eng_status_t                               status
);

    localparam int KW = $clog2(KEYS);
    localparam int SW = $clog2(SLOTS);

    // Unpacked input fields
    logic [ADDR_W-1:0] in_site;
    logic [CODE_W-1:0] in_code;
    logic [VAL_W-1:0]  in_opa;
    logic [VAL_W-1:0]  in_opb;
    logic [KEY_W-1:0]  in_rkey;
    logic [SLOT_W-1:0] in_rslot;
    logic [ADDR_W-1:0] hash_word;
    logic [KW-1:0]     hash_key;
    logic [KW-1:0]     rd_key;
    logic [SW-1:0]     rd_slot;
    logic              s_fire;
    logic              out_free;

    // Registers
    eng_state_t           state_reg, state_next;
    logic [KW-1:0]        clr_addr_reg, clr_addr_next;
    logic                 act_reg, act_next;
    logic [KW-1:0]        key_reg, key_next;
    logic [SW-1:0]        slot_reg, slot_next;
    logic [CODE_W-1:0]    code_reg, code_next;
    logic [VAL_W-1:0]     opa_reg, opa_next;
    logic [VAL_W-1:0]     opb_reg, opb_next;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [OUT_DATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic                 m_tuser_reg, m_tuser_next;

    // Result fields under construction
    logic [SW-1:0]        rec_slot;
    logic [SHAPE_W-1:0]   rec_shape;
    logic                 r_done;
    logic [KEY_W-1:0]     r_key;
    logic [HITS_W-1:0]    r_hits;
    logic [SLOT_W-1:0]    r_slot;
    logic [SHAPE_W-1:0]   r_shape;
    logic                 r_kind;
    logic [VAL_W-1:0]     r_va;
    logic [VAL_W-1:0]     r_vb;

    // Split input payload
    assign in_site  = s_tdata[63:0];
    assign in_code  = s_tdata[65:64];
    assign in_opa   = s_tdata[129:66];
    assign in_opb   = s_tdata[193:130];
    assign in_rkey  = s_tdata[203:194];
    assign in_rslot = s_tdata[208:204];

    // Key hash and reduced read indexes
    assign hash_word = (in_site >> HASH_SHR) ^ (in_site << HASH_SHL);
    assign hash_key  = hash_word[KW-1:0];
    assign rd_key    = KW'(in_rkey);
    assign rd_slot   = SW'(in_rslot);

    assign s_tready = (state_reg == ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    // Record slot follows from the header just read, shape from the size code
    assign rec_slot  = hdr_rdata.hits[SW-1:0];
    assign rec_shape = shape_of(code_reg);

    // Next state, memory accesses and result
    always_comb
    begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        act_next      = act_reg;
        key_next      = key_reg;
        slot_next     = slot_reg;
        code_next     = code_reg;
        opa_next      = opa_reg;
        opb_next      = opb_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;

        hdr_we    = 1'b0;
        hdr_waddr = key_reg;
        hdr_wdata = '0;
        hdr_re    = 1'b0;
        hdr_raddr = hash_key;
        log_we    = 1'b0;
        log_waddr = {key_reg, rec_slot};
        log_wdata = {size_cut(code_reg, opb_reg), size_cut(code_reg, opa_reg)};
        log_re    = 1'b0;
        log_raddr = {rd_key, rd_slot};

        r_done  = 1'b0;
        r_key   = '0;
        r_hits  = '0;
        r_slot  = '0;
        r_shape = '0;
        r_kind  = KIND_NONE;
        r_va    = '0;
        r_vb    = '0;

        case (state_reg)
            ST_CLEAR:
            begin
                // Zero one header entry per cycle
                hdr_we        = 1'b1;
                hdr_waddr     = clr_addr_reg;
                clr_addr_next = KW'(clr_addr_reg + 1'b1);
                if (clr_addr_reg == KW'(KEYS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                // Take an item and issue the reads
                if (s_fire)
                begin
                    act_next  = s_tuser;
                    code_next = in_code;
                    opa_next  = in_opa;
                    opb_next  = in_opb;
                    slot_next = rd_slot;
                    hdr_re    = 1'b1;
                    if (s_tuser == ACT_READ)
                    begin
                        hdr_raddr = rd_key;
                        key_next  = rd_key;
                        log_re    = 1'b1;
                    end
                    else
                    begin
                        key_next  = hash_key;
                    end
                    state_next = ST_LOOK;
                end
            end

            ST_LOOK:
            begin
                // Hold read data until the output register is free
                if (out_free)
                begin
                    if (act_reg == ACT_READ)
                    begin
                        r_done  = 1'b1;
                        r_key   = KEY_W'(key_reg);
                        r_hits  = hdr_rdata.hits;
                        r_slot  = SLOT_W'(slot_reg);
                        r_shape = hdr_rdata.shape;
                        r_kind  = hdr_rdata.kind;
                        r_va    = log_rdata[VAL_W-1:0];
                        r_vb    = log_rdata[2*VAL_W-1:VAL_W];
                    end
                    else if (log_enable)
                    begin
                        // Write back header and store operand pair
                        hdr_we          = 1'b1;
                        hdr_wdata.kind  = KIND_INSN;
                        hdr_wdata.shape = rec_shape;
                        hdr_wdata.hits  = HITS_W'(hdr_rdata.hits + 1'b1);
                        log_we          = 1'b1;
                        r_done  = 1'b1;
                        r_key   = KEY_W'(key_reg);
                        r_hits  = hdr_rdata.hits;
                        r_slot  = SLOT_W'(rec_slot);
                        r_shape = rec_shape;
                        r_kind  = KIND_INSN;
                    end
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = r_done;
                    m_tdata_next  = {{(OUT_DATA_W-OUT_BITS){1'b0}},
                                     r_vb, r_va, r_kind, r_shape, r_slot, r_hits, r_key};
                    state_next    = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            clr_addr_reg <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        act_reg     <= act_next;
        key_reg     <= key_next;
        slot_reg    <= slot_next;
        code_reg    <= code_next;
        opa_reg     <= opa_next;
        opb_reg     <= opb_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign m_tvalid        = m_tvalid_reg;
    assign m_tdata         = m_tdata_reg;
    assign m_tuser         = m_tuser_reg;
    assign status.clearing = (state_reg == ST_CLEAR);
    assign status.busy     = (state_reg == ST_LOOK);

endmodule
